@@ rtl/core/owm_pkg.sv @@
// owm_pkg: shared types and codes for the 1-wire bus master
// beat payload structs, command codes, register indexes, address and register widths
// no dependencies
package owm_pkg;

	// command codes carried in the mode field
	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_RESET = 3'd1;
	localparam logic [2:0] MODE_WR0   = 3'd2;
	localparam logic [2:0] MODE_WR1   = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	// configuration register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_RESET_LOW   = 3'd0;
	localparam logic [2:0] REG_PRES_WINDOW = 3'd1;
	localparam logic [2:0] REG_SLOT        = 3'd2;
	localparam logic [2:0] REG_WR1_LOW     = 3'd3;
	localparam logic [2:0] REG_READ_LOW    = 3'd4;
	localparam logic [2:0] REG_READ_SAMPLE = 3'd5;
	localparam logic [2:0] REG_RECOVERY    = 3'd6;

	localparam int ADDR_BITS = 5;
	localparam int REG_BITS  = 10;

	// reset values of the timing registers
	localparam logic [REG_BITS-1:0] RST_RESET_LOW   = 10'd500;
	localparam logic [REG_BITS-1:0] RST_PRES_WINDOW = 10'd500;
	localparam logic [REG_BITS-1:0] RST_SLOT        = 10'd60;
	localparam logic [REG_BITS-1:0] RST_WR1_LOW     = 10'd1;
	localparam logic [REG_BITS-1:0] RST_READ_LOW    = 10'd2;
	localparam logic [REG_BITS-1:0] RST_READ_SAMPLE = 10'd10;
	localparam logic [REG_BITS-1:0] RST_RECOVERY    = 10'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic       bus_level;
	} cmd_t;

	typedef struct packed {
		logic drive_low;
		logic busy_res;
		logic done_res;
		logic read_value;
		logic device_present;
		logic no_device;
	} res_t;

endpackage

@@ rtl/core/onewire_bus_master.sv @@
// onewire_bus_master: 1-wire slot sequencer with apb timing registers
// depends on owm_pkg for payload structs, command codes and register indexes
//
// channel   handshake              payload      direction
// cmd       cmd_valid / cmd_ready  owm_pkg::cmd_t  in   one tick or command per beat
// res       res_valid / res_ready  owm_pkg::res_t  out  one result beat per cmd beat
// apb       psel/penable/pready    pwdata/prdata   cfg  seven 10-bit timing registers
//
// one cmd beat is taken per cycle while the output register is empty or being drained;
// its result appears in the output register on the next cycle
// the sequencer state (phase, tick counter, presence flags) moves on the accepting edge
// a stalled result beat only blocks cmd while it is held and not being taken
// arst_n clears the sequencer to idle and loads the timing registers' reset values
// no clearing pass: the block is ready as soon as reset is released
module onewire_bus_master #(
	parameter int COUNT_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command beats
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  owm_pkg::cmd_t                  cmd,
	// result beats
	output logic                           res_valid,
	input  logic                           res_ready,
	output owm_pkg::res_t                  res,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [owm_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	// compare width covers both the register width and the counter width
	localparam int SPAN_BITS = (COUNT_BITS > owm_pkg::REG_BITS) ? COUNT_BITS
	                                                            : owm_pkg::REG_BITS;
	localparam logic [SPAN_BITS-1:0] CNT_MAX = SPAN_BITS'((1 << COUNT_BITS) - 1);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_PRESENCE,
		PH_W0_LOW,
		PH_W0_REC,
		PH_W1_LOW,
		PH_W1_TAIL,
		PH_RD_LOW,
		PH_RD_WAIT,
		PH_RD_TAIL
	} phase_t;

	// timing registers
	logic [owm_pkg::REG_BITS-1:0] reset_low_q;
	logic [owm_pkg::REG_BITS-1:0] pres_window_q;
	logic [owm_pkg::REG_BITS-1:0] slot_q;
	logic [owm_pkg::REG_BITS-1:0] wr1_low_q;
	logic [owm_pkg::REG_BITS-1:0] read_low_q;
	logic [owm_pkg::REG_BITS-1:0] read_sample_q;
	logic [owm_pkg::REG_BITS-1:0] recovery_q;

	// sequencer state
	phase_t                phase_q, phase_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic                  saw_low_q, saw_low_d;
	logic                  presence_q, presence_d;
	logic                  sampled_q, sampled_d;

	// output register
	logic          res_valid_q;
	owm_pkg::res_t res_q;
	owm_pkg::res_t res_d;

	logic                         cmd_take;
	logic                         cfg_write;
	logic [2:0]                   reg_idx;
	logic [owm_pkg::REG_BITS-1:0] span_reg;
	logic [SPAN_BITS-1:0]         span_ext;
	logic [SPAN_BITS-1:0]         limit;
	logic [COUNT_BITS-1:0]        cnt_inc;
	logic                         span_hit;
	logic                         done;
	logic                         nodev;

	// ---------------------------------------------------------------- apb port
	assign pready    = 1'b1;
	assign reg_idx   = paddr[owm_pkg::ADDR_BITS-1:2];
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			owm_pkg::REG_RESET_LOW:   prdata = 32'(reset_low_q);
			owm_pkg::REG_PRES_WINDOW: prdata = 32'(pres_window_q);
			owm_pkg::REG_SLOT:        prdata = 32'(slot_q);
			owm_pkg::REG_WR1_LOW:     prdata = 32'(wr1_low_q);
			owm_pkg::REG_READ_LOW:    prdata = 32'(read_low_q);
			owm_pkg::REG_READ_SAMPLE: prdata = 32'(read_sample_q);
			owm_pkg::REG_RECOVERY:    prdata = 32'(recovery_q);
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q   <= owm_pkg::RST_RESET_LOW;
			pres_window_q <= owm_pkg::RST_PRES_WINDOW;
			slot_q        <= owm_pkg::RST_SLOT;
			wr1_low_q     <= owm_pkg::RST_WR1_LOW;
			read_low_q    <= owm_pkg::RST_READ_LOW;
			read_sample_q <= owm_pkg::RST_READ_SAMPLE;
			recovery_q    <= owm_pkg::RST_RECOVERY;
		end else if (cfg_write) begin
			// unmapped addresses are dropped
			unique case (reg_idx)
				owm_pkg::REG_RESET_LOW:   reset_low_q   <= pwdata[owm_pkg::REG_BITS-1:0];
				owm_pkg::REG_PRES_WINDOW: pres_window_q <= pwdata[owm_pkg::REG_BITS-1:0];
				owm_pkg::REG_SLOT:        slot_q        <= pwdata[owm_pkg::REG_BITS-1:0];
				owm_pkg::REG_WR1_LOW:     wr1_low_q     <= pwdata[owm_pkg::REG_BITS-1:0];
				owm_pkg::REG_READ_LOW:    read_low_q    <= pwdata[owm_pkg::REG_BITS-1:0];
				owm_pkg::REG_READ_SAMPLE: read_sample_q <= pwdata[owm_pkg::REG_BITS-1:0];
				owm_pkg::REG_RECOVERY:    recovery_q    <= pwdata[owm_pkg::REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	// a new beat enters whenever the output register is empty or being drained
	assign cmd_ready = !res_valid_q || res_ready;
	assign cmd_take  = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------------------------------------------------------- span select
	// each phase times against one register
	always_comb begin
		unique case (phase_q)
			PH_RST_LOW:  span_reg = reset_low_q;
			PH_PRESENCE: span_reg = pres_window_q;
			PH_W0_LOW:   span_reg = slot_q;
			PH_W0_REC:   span_reg = recovery_q;
			PH_W1_LOW:   span_reg = wr1_low_q;
			PH_W1_TAIL:  span_reg = slot_q;
			PH_RD_LOW:   span_reg = read_low_q;
			PH_RD_WAIT:  span_reg = read_sample_q;
			PH_RD_TAIL:  span_reg = slot_q;
			default:     span_reg = reset_low_q;
		endcase
	end

	// zero span acts as one, a span beyond the counter range is clipped
	assign span_ext = SPAN_BITS'(span_reg);
	always_comb begin
		priority if (span_ext == '0)
			limit = SPAN_BITS'(1);
		else if (span_ext > CNT_MAX)
			limit = CNT_MAX;
		else
			limit = span_ext;
	end

	// counter saturates at its top value
	assign cnt_inc  = (cnt_q != '1) ? cnt_q + COUNT_BITS'(1) : cnt_q;
	assign span_hit = SPAN_BITS'(cnt_inc) >= limit;

	// ---------------------------------------------------------------- next state
	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		saw_low_d  = saw_low_q;
		presence_d = presence_q;
		sampled_d  = sampled_q;
		done       = 1'b0;
		nodev      = 1'b0;

		if (phase_q == PH_IDLE) begin
			// commands start a sequence, ticks and unused codes do nothing
			cnt_d = '0;
			unique case (cmd.mode)
				owm_pkg::MODE_RESET: begin
					phase_d    = PH_RST_LOW;
					saw_low_d  = 1'b0;
					presence_d = 1'b0;
				end
				owm_pkg::MODE_WR0:  phase_d = PH_W0_LOW;
				owm_pkg::MODE_WR1:  phase_d = PH_W1_LOW;
				owm_pkg::MODE_READ: phase_d = PH_RD_LOW;
				default:            cnt_d   = cnt_q;
			endcase
		end else if (cmd.mode == owm_pkg::MODE_TICK) begin
			cnt_d = span_hit ? '0 : cnt_inc;
			unique case (phase_q)
				PH_RST_LOW: begin
					if (span_hit) phase_d = PH_PRESENCE;
				end
				PH_PRESENCE: begin
					// presence is a low followed later by a high
					if (!saw_low_q) begin
						if (!cmd.bus_level) saw_low_d = 1'b1;
					end else if (cmd.bus_level) begin
						presence_d = 1'b1;
					end
					if (span_hit) begin
						phase_d = PH_IDLE;
						done    = 1'b1;
						nodev   = !presence_d;
					end
				end
				PH_W0_LOW: begin
					if (span_hit) phase_d = PH_W0_REC;
				end
				PH_W1_LOW: begin
					if (span_hit) phase_d = PH_W1_TAIL;
				end
				PH_RD_LOW: begin
					if (span_hit) phase_d = PH_RD_WAIT;
				end
				PH_RD_WAIT: begin
					if (span_hit) begin
						sampled_d = cmd.bus_level;
						phase_d   = PH_RD_TAIL;
					end
				end
				PH_W0_REC, PH_W1_TAIL, PH_RD_TAIL: begin
					if (span_hit) begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
				end
			endcase
		end

		res_d.drive_low      = (phase_d == PH_RST_LOW) || (phase_d == PH_W0_LOW) ||
		                       (phase_d == PH_W1_LOW)  || (phase_d == PH_RD_LOW);
		res_d.busy_res       = (phase_d != PH_IDLE);
		res_d.done_res       = done;
		res_d.read_value     = sampled_d;
		res_d.device_present = presence_d;
		res_d.no_device      = nodev;
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			saw_low_q   <= 1'b0;
			presence_q  <= 1'b0;
			sampled_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				phase_q    <= phase_d;
				cnt_q      <= cnt_d;
				saw_low_q  <= saw_low_d;
				presence_q <= presence_d;
				sampled_q  <= sampled_d;
			end
			if (cmd_ready) res_valid_q <= cmd_valid;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_take) res_q <= res_d;
	end

endmodule

@@ rtl/core/owm_checker.sv @@
// owm_checker: port-level checks for onewire_bus_master, bound to the top level
// depends on owm_pkg for the payload structs
module owm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input logic          res_valid,
	input logic          res_ready,
	input owm_pkg::res_t res
);

	// a finishing beat never shows the sequence still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done_res |-> !res.busy_res)
		else $error("done beat shows busy");

	// no-device only on the finishing beat and never with presence
	a_nodev: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.no_device |-> res.done_res && !res.device_present)
		else $error("no_device outside a finishing beat or with presence");

	// the bus is only pulled low during a running sequence
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.drive_low |-> res.busy_res)
		else $error("drive_low while idle");

	// an accepted command beat yields a result beat in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> res_valid)
		else $error("result beat missing after accepted command");

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result beat changed");

endmodule

bind onewire_bus_master owm_checker u_owm_checker (.*);
